// ===== hw/rtl/crc8_word_reply_checker_unit_defines.svh =====
// assertion macros for the crc8 word reply checker
// no dependencies; expects clk and rst in the including scope
`ifndef CRC8_WORD_REPLY_CHECKER_UNIT_DEFINES_SVH
`define CRC8_WORD_REPLY_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CRCWRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crcwrc assertion failed");
`define CRCWRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crcwrc assertion failed");
`else
`define CRCWRC_ASSERT_SAME(label, ante, cons)
`define CRCWRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/crcwrc_pkg.sv =====
// package for the crc8 word reply checker: constants, types, crc byte step
// no dependencies
package crcwrc_pkg;

  localparam logic [7:0] CRC_TOP_BIT   = 8'h80;
  localparam logic [7:0] POLY_RESET    = 8'h31;
  localparam logic [7:0] INIT_RESET    = 8'hFF;

  typedef enum logic {
    CFG_POLY = 1'b0,
    CFG_INIT = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] word_value;
    logic        word_crc_ok;
    logic [31:0] pair_value;
    logic        pair_valid;
  } result_t;

  function automatic logic [7:0] crc_byte_step(input logic [7:0] crc,
                                               input logic [7:0] data,
                                               input logic [7:0] poly);
    logic [7:0] r;
    r = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_TOP_BIT) != 8'd0) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/crc8_word_reply_checker_unit.sv =====
// crc8 word reply checker: groups reply bytes into high, low, crc triples
// and emits each checked word; depends on crcwrc_pkg and the defines header
//
// usage:
//   input channel (in_valid, in_stall, rx_byte, frame_start) takes one reply
//   byte per transaction; frame_start marks the first byte of a reply frame
//   output channel (out_valid, out_stall, word_value, word_crc_ok, pair_value,
//   pair_valid) gives one transaction for every third byte of a triple
//   a byte is taken every cycle while in_stall is low; the crc step is one unrolled 8-bit stage
//   between the input and the running crc register
//   the result of a crc byte is registered into the output register
//   a stalled output keeps its result; one more result goes into a skid
//   register, and in_stall rises only while that skid register is full
//   after a crc mismatch the word is still sent, flagged bad, and the rest of
//   the frame is dropped until the next frame_start
//   config writes (cfg_wr_en, cfg_index, cfg_data) are registered:
//   index 0 is the polynomial, index 1 the crc start value
//   reset (rst, synchronous) restores polynomial 0x31, start value 0xff,
//   clears the byte phase, pairing and abort state, and empties the output
`include "crc8_word_reply_checker_unit_defines.svh"

module crc8_word_reply_checker_unit
  import crcwrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] word_value,
  output logic        word_crc_ok,
  output logic [31:0] pair_value,
  output logic        pair_valid
);

  logic [7:0]  crc_polynomial;
  logic [7:0]  crc_initial;
  phase_t      byte_phase, byte_phase_next, phase_eff;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic        word_parity, word_parity_next, parity_eff;
  logic [15:0] upper_word_hold, upper_word_hold_next;
  logic        frame_aborted, frame_aborted_next, aborted_eff;

  logic        in_fire;
  logic        produce;
  result_t     new_res;
  result_t     out_res;
  result_t     skid_res;
  logic        skid_valid;
  logic [15:0] word;
  logic        ok;

  assign in_stall    = skid_valid;
  assign in_fire     = in_valid && !in_stall;
  assign phase_eff   = frame_start ? PH_HIGH : byte_phase;
  assign parity_eff  = frame_start ? 1'b0 : word_parity;
  assign aborted_eff = frame_start ? 1'b0 : frame_aborted;
  assign word        = {high_byte_hold, low_byte_hold};
  assign ok          = (running_crc == rx_byte);

  // byte phase next state
  always_comb begin
    byte_phase_next = byte_phase;
    if (in_fire) begin
      if (aborted_eff) begin
        byte_phase_next = byte_phase;
      end else begin
        case (phase_eff)
          PH_LOW:  byte_phase_next = PH_CRC;
          PH_CRC:  byte_phase_next = PH_HIGH;
          default: byte_phase_next = PH_LOW;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    running_crc_next     = running_crc;
    high_byte_hold_next  = high_byte_hold;
    low_byte_hold_next   = low_byte_hold;
    word_parity_next     = word_parity;
    upper_word_hold_next = upper_word_hold;
    frame_aborted_next   = frame_aborted;
    produce              = 1'b0;
    new_res.word_value   = word;
    new_res.word_crc_ok  = ok;
    new_res.pair_valid   = ok && parity_eff;
    new_res.pair_value   = (ok && parity_eff) ? {upper_word_hold, word} : 32'd0;
    if (in_fire) begin
      word_parity_next   = parity_eff;
      frame_aborted_next = aborted_eff;
      if (!aborted_eff) begin
        case (phase_eff)
          PH_LOW: begin
            low_byte_hold_next = rx_byte;
            running_crc_next   = crc_byte_step(running_crc, rx_byte, crc_polynomial);
          end
          PH_CRC: begin
            produce          = 1'b1;
            running_crc_next = crc_initial;
            if (ok) begin
              upper_word_hold_next = word;
              word_parity_next     = !parity_eff;
            end else begin
              frame_aborted_next = 1'b1;
            end
          end
          default: begin
            high_byte_hold_next = rx_byte;
            running_crc_next    = crc_byte_step(crc_initial, rx_byte, crc_polynomial);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= POLY_RESET;
      crc_initial    <= INIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_POLY: crc_polynomial <= cfg_data;
        CFG_INIT: crc_initial    <= cfg_data;
        default:  crc_polynomial <= crc_polynomial;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase      <= PH_HIGH;
      running_crc     <= INIT_RESET;
      high_byte_hold  <= 8'd0;
      low_byte_hold   <= 8'd0;
      word_parity     <= 1'b0;
      upper_word_hold <= 16'd0;
      frame_aborted   <= 1'b0;
    end else begin
      byte_phase      <= byte_phase_next;
      running_crc     <= running_crc_next;
      high_byte_hold  <= high_byte_hold_next;
      low_byte_hold   <= low_byte_hold_next;
      word_parity     <= word_parity_next;
      upper_word_hold <= upper_word_hold_next;
      frame_aborted   <= frame_aborted_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (produce) begin
        out_res <= new_res;
      end
    end else if (produce) begin
      skid_res <= new_res;
    end
  end

  assign word_value  = out_res.word_value;
  assign word_crc_ok = out_res.word_crc_ok;
  assign pair_value  = out_res.pair_value;
  assign pair_valid  = out_res.pair_valid;

  `CRCWRC_ASSERT_SAME(a_skid_needs_out, skid_valid, out_valid)
  `CRCWRC_ASSERT_SAME(a_pair_needs_ok, out_valid && out_res.pair_valid, out_res.word_crc_ok)
  `CRCWRC_ASSERT_SAME(a_pair_zero, out_valid && !out_res.pair_valid, out_res.pair_value == 32'd0)
  `CRCWRC_ASSERT_NEXT(a_aborted_holds, in_fire && frame_aborted && !frame_start, $stable(byte_phase) && $stable(upper_word_hold))
  `CRCWRC_ASSERT_NEXT(a_stalled_result_to_skid, produce && out_valid && out_stall, skid_valid)

endmodule

// ===== dv/testbench.sv =====
// testbench for crc8_word_reply_checker_unit: directed table, then random reply frames
// predicts checked words with its own crc-8 deframer model (directed rows carry their own) and scoreboards the output
// depends on crcwrc_pkg and the rtl top level only
`timescale 1ns / 1ps

module testbench;
  import crcwrc_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       s;
    bit         typed;
    result_t    exp;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 23;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 133;
  localparam int LONG_HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] word_value;
  logic        word_crc_ok;
  logic [31:0] pair_value;
  logic        pair_valid;

  // configuration copy and deframer state
  logic [7:0]  cur_poly;
  logic [7:0]  cur_init;
  phase_t      pred_phase;
  logic [7:0]  pred_crc;
  logic [7:0]  pred_hi;
  logic [7:0]  pred_lo;
  logic        pred_parity;
  logic [15:0] pred_upper;
  logic        pred_aborted;

  result_t expected_words[$];
  result_t seen_word;
  result_t due_word;
  int      word_mismatches = 0;
  int      items_sent = 0;
  bit      idling_on = 1'b1;
  bit      long_hold_req = 1'b0;

  dir_row_t directed_rows [0:NUM_DIR_ROWS-1] = '{
    '{8'hBE, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},
    '{8'h92, 1'b0, 1'b1, {16'hBEEF, 1'b1, 32'h0000_0000, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b1, {16'h0000, 1'b1, 32'hBEEF_0000, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, {16'h0000, 1'b0, 32'h0000_0000, 1'b0}},
    '{8'hAA, 1'b1, 1'b0, '0},
    '{8'hBE, 1'b1, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},
    '{8'h92, 1'b0, 1'b1, {16'hBEEF, 1'b1, 32'h0000_0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}
  };

  crc8_word_reply_checker_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .word_value  (word_value),
    .word_crc_ok (word_crc_ok),
    .pair_value  (pair_value),
    .pair_valid  (pair_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // serial form: one feedback decision per data bit, msb first
  function automatic logic [7:0] crc8_msb_first(input logic [7:0] crc, input logic [7:0] data,
                                                input logic [7:0] poly);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

  function automatic bit predict_reply_byte(input logic [7:0] b, input logic s,
                                            output result_t r);
    logic [15:0] w;
    bit          ok;
    r = '0;
    if (s) begin
      pred_phase = PH_HIGH;
      pred_parity = 1'b0;
      pred_aborted = 1'b0;
    end
    if (pred_aborted) begin
      return 1'b0;
    end
    case (pred_phase)
      PH_LOW: begin
        pred_lo = b;
        pred_crc = crc8_msb_first(pred_crc, b, cur_poly);
        pred_phase = PH_CRC;
        return 1'b0;
      end
      PH_CRC: begin
        w = {pred_hi, pred_lo};
        ok = (pred_crc == b);
        r.word_value = w;
        r.word_crc_ok = ok;
        if (ok && pred_parity) begin
          r.pair_value = {pred_upper, w};
          r.pair_valid = 1'b1;
        end
        if (ok) begin
          pred_upper = w;
          pred_parity = ~pred_parity;
        end else begin
          pred_aborted = 1'b1;
        end
        pred_crc = cur_init;
        pred_phase = PH_HIGH;
        return 1'b1;
      end
      default: begin
        pred_hi = b;
        pred_crc = crc8_msb_first(cur_init, b, cur_poly);
        pred_phase = PH_LOW;
        return 1'b0;
      end
    endcase
  endfunction

  // append one expected transaction at the tail of the scoreboard queue
  function automatic void queue_expected(input result_t r);
    expected_words = {expected_words, r};
  endfunction

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 8'h00;
    end else if (sel == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge; returns at a falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                           input result_t typed_word);
    result_t w;
    bit      has_word;
    rx_byte <= b;
    frame_start <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    has_word = predict_reply_byte(b, s, w);
    if (has_word) begin
      queue_expected(typed ? typed_word : w);
    end
    items_sent++;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic send_frame(input int n_words, input bit truncate);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] crc;
    int         cut;
    for (int w = 0; w < n_words; w++) begin
      hi = pick_byte();
      lo = pick_byte();
      crc = crc8_msb_first(crc8_msb_first(cur_init, hi, cur_poly), lo, cur_poly);
      if ($urandom_range(0, 9) == 0) begin
        crc = crc ^ 8'($urandom_range(1, 255));
      end
      cut = (truncate && w == n_words - 1) ? $urandom_range(1, 2) : 3;
      send_byte(hi, (w == 0), 1'b0, '0);
      if (cut >= 2) begin
        send_byte(lo, 1'b0, 1'b0, '0);
      end
      if (cut == 3) begin
        send_byte(crc, 1'b0, 1'b0, '0);
      end
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // both registers in back-to-back cycles, enable held high across them
  task automatic set_crc_config(input logic [7:0] poly, input logic [7:0] init);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_POLY;
    cfg_data <= poly;
    cur_poly = poly;
    @(negedge clk);
    cfg_index <= CFG_INIT;
    cfg_data <= init;
    cur_init = init;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int         phase_start;
    int         unit_sel;
    logic [7:0] ph_poly [0:4];
    logic [7:0] ph_init [0:4];
    ph_poly = '{8'h31, 8'h00, 8'hFF, 8'hFF, 8'h00};
    ph_init = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_POLY;
    cfg_data = 8'h00;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    frame_start = 1'b0;
    cur_poly = POLY_RESET;
    cur_init = INIT_RESET;
    pred_phase = PH_HIGH;
    pred_crc = INIT_RESET;
    pred_hi = 8'h00;
    pred_lo = 8'h00;
    pred_parity = 1'b0;
    pred_upper = 16'h0000;
    pred_aborted = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    for (int i = 0; i < NUM_DIR_ROWS; i++) begin
      send_byte(directed_rows[i].b, directed_rows[i].s, directed_rows[i].typed,
                directed_rows[i].exp);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p > 0 && p < 5) begin
        set_crc_config(ph_poly[p], ph_init[p]);
      end else if (p >= 5) begin
        set_crc_config(pick_byte(), pick_byte());
      end
      if (p == 1) begin
        long_hold_req = 1'b1;
      end
      if (p == NUM_PHASES - 1) begin
        idling_on = 1'b0;
      end
      // random bytes, some with a frame start, right after a write test mid-word updates
      if ($urandom_range(0, 1) == 0) begin
        send_noise($urandom_range(1, 3));
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        unit_sel = $urandom_range(0, 9);
        if (unit_sel < 8) begin
          send_frame($urandom_range(1, 6), 1'b0);
        end else if (unit_sel == 8) begin
          send_frame($urandom_range(1, 3), 1'b1);
        end else begin
          send_noise($urandom_range(1, 5));
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        send_byte(pick_byte(), 1'b1, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (word_mismatches == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word = {word_value, word_crc_ok, pair_value, pair_valid};
      if (expected_words.size() == 0) begin
        word_mismatches++;
        if (word_mismatches <= 10) begin
          $display("unexpected transaction: word %h ok %b pair %h valid %b",
                   seen_word.word_value, seen_word.word_crc_ok, seen_word.pair_value,
                   seen_word.pair_valid);
        end
      end else begin
        due_word = expected_words.pop_front();
        if (seen_word.word_value !== due_word.word_value ||
            seen_word.word_crc_ok !== due_word.word_crc_ok ||
            seen_word.pair_value !== due_word.pair_value ||
            seen_word.pair_valid !== due_word.pair_valid) begin
          word_mismatches++;
          if (word_mismatches <= 10) begin
            $display("mismatch: expected word %h ok %b pair %h valid %b, got word %h ok %b pair %h valid %b",
                     due_word.word_value, due_word.word_crc_ok, due_word.pair_value,
                     due_word.pair_valid, seen_word.word_value, seen_word.word_crc_ok,
                     seen_word.pair_value, seen_word.pair_valid);
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/crcwrc_pkg.sv
hw/rtl/crc8_word_reply_checker_unit.sv
dv/testbench.sv
